// ----- rtl/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Shared widths, defaults and the table entry layout of the frame reassembly
// tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam int unsigned IdW   = 32;
  localparam int unsigned LenW  = 24;
  localparam int unsigned FragW = 16;

  // Stream widths: input fields fill 9 bytes, output data pads to 8 bytes.
  localparam int unsigned SDataW = IdW + LenW + FragW;
  localparam int unsigned MDataW = 64;
  localparam int unsigned MUserW = 2;

  localparam logic [LenW-1:0] LenMax = '1;

  typedef struct packed {
    logic [IdW-1:0]  frame_id;
    logic [LenW-1:0] length;
    logic [LenW-1:0] bytes_seen;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ----- rtl/frt_ram.sv -----
// ----------------------------------------------------------------------------
// frt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/frame_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// frame_reassembly_tracker
// Per-fragment byte counting over a table of open frames held in one RAM.
// ----------------------------------------------------------------------------
// Timing: the input transfer starts a walk over the table, and a hit in entry k ends
//   it early; the result register is then loaded once the sink has freed it.
// Flow: the input stays closed until that load, so a new fragment is not taken
//   before the last is through; the walk through the single RAM read port sets the pace.
// Reset: valid bits clear at once; RAM contents are not reset and need no clearing
//   pass, an entry's word only counts while its valid bit is set.
module frame_reassembly_tracker #(
  parameter int unsigned TableEntries = frt_pkg::TableEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Fragment in.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] frame_id, [55:32] total_length, [71:56] fragment_bytes
  input  logic [frt_pkg::SDataW-1:0]  s_axis_tdata,
  // Result out.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] done_frame_id, [55:32] done_length, [63:56] zero
  output logic [frt_pkg::MDataW-1:0]  m_axis_tdata,
  // [0] frame_complete, [1] table_full_drop
  output logic [frt_pkg::MUserW-1:0]  m_axis_tuser
);

  localparam int unsigned IdW   = frt_pkg::IdW;
  localparam int unsigned LenW  = frt_pkg::LenW;
  localparam int unsigned FragW = frt_pkg::FragW;
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  // Idle waits for a fragment, scan walks the table one entry per cycle,
  // update writes back the touched entry, if any, and loads the result register.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } state_e;

  state_e                 state_q, state_d;
  logic [TableEntries-1:0] valid_q, valid_d;
  logic [IdxW-1:0]        chk_q, chk_d;
  logic                   hit_q, hit_d;
  logic                   free_q, free_d;
  logic                   m_valid_q, m_valid_d;

  // Fragment held for the duration of the walk.
  logic [IdW-1:0]         id_q, id_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [FragW-1:0]       frag_q, frag_d;
  // Matching entry, captured as it streams out of the RAM.
  logic [IdxW-1:0]        hit_idx_q, hit_idx_d;
  logic [LenW-1:0]        hit_len_q, hit_len_d;
  logic [LenW-1:0]        hit_bytes_q, hit_bytes_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  // Result register.
  logic                   m_complete_q, m_complete_d;
  logic                   m_drop_q, m_drop_d;
  logic [IdW-1:0]         m_id_q, m_id_d;
  logic [LenW-1:0]        m_len_q, m_len_d;

  // RAM port signals.
  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  frt_pkg::entry_t        ram_wdata;
  logic [IdxW-1:0]        ram_raddr;
  logic [frt_pkg::EntryW-1:0] ram_rdata;

  frt_pkg::entry_t        rd_entry;
  logic                   in_xfer;
  logic                   live;
  logic                   match;
  logic                   out_free;
  logic [LenW:0]          sum_full;
  logic [LenW-1:0]        sum_sat;
  logic [LenW-1:0]        frag_ext;

  frt_ram #(
    .Width(frt_pkg::EntryW),
    .Depth(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // The RAM word for entry chk_q is on the read port during the scan.
  assign rd_entry = frt_pkg::entry_t'(ram_rdata);
  assign live     = valid_q[chk_q];
  assign match    = live && (rd_entry.frame_id == id_q);

  // Running count with saturation at the largest length.
  assign frag_ext = {{(LenW - FragW){1'b0}}, frag_q};
  assign sum_full = {1'b0, hit_bytes_q} + {1'b0, frag_ext};
  assign sum_sat  = sum_full[LenW] ? frt_pkg::LenMax : sum_full[LenW-1:0];

  // The result register may be reloaded once its current transfer completes.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    chk_d        = chk_q;
    hit_d        = hit_q;
    free_d       = free_q;
    m_valid_d    = m_valid_q;
    id_d         = id_q;
    len_d        = len_q;
    frag_d       = frag_q;
    hit_idx_d    = hit_idx_q;
    hit_len_d    = hit_len_q;
    hit_bytes_d  = hit_bytes_q;
    free_idx_d   = free_idx_q;
    m_complete_d = m_complete_q;
    m_drop_d     = m_drop_q;
    m_id_d       = m_id_q;
    m_len_d      = m_len_q;

    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = '{frame_id: id_q, length: hit_len_q, bytes_seen: sum_sat};
    ram_raddr = '0;

    // Drop the result once the sink takes it.
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        // Start the walk: entry 0 is read in the transfer cycle.
        if (in_xfer) begin
          id_d    = s_axis_tdata[IdW-1:0];
          len_d   = s_axis_tdata[IdW +: LenW];
          frag_d  = s_axis_tdata[IdW+LenW +: FragW];
          chk_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = StScan;
        end
      end

      StScan: begin
        // Prefetch the next entry while checking this one.
        ram_raddr = (chk_q == LastIdx) ? '0 : chk_q + 1'b1;
        if (match) begin
          // Lowest matching entry wins; stop the walk here.
          hit_d       = 1'b1;
          hit_idx_d   = chk_q;
          hit_len_d   = rd_entry.length;
          hit_bytes_d = rd_entry.bytes_seen;
          state_d     = StUpdate;
        end else begin
          if (!live && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_q;
          end
          if (chk_q == LastIdx) begin
            state_d = StUpdate;
          end else begin
            chk_d = chk_q + 1'b1;
          end
        end
      end

      StUpdate: begin
        // Hold until the result register is free.
        if (out_free) begin
          m_valid_d    = 1'b1;
          m_complete_d = 1'b0;
          m_drop_d     = 1'b0;
          m_id_d       = '0;
          m_len_d      = '0;
          state_d      = StIdle;
          if (hit_q) begin
            // Open frame: add the bytes, free the entry when the count lands.
            ram_we    = 1'b1;
            ram_waddr = hit_idx_q;
            if (sum_sat == hit_len_q) begin
              valid_d[hit_idx_q] = 1'b0;
              m_complete_d       = 1'b1;
              m_id_d             = id_q;
              m_len_d            = hit_len_q;
            end
          end else if (frag_ext == len_q) begin
            // Whole frame in one fragment: report, take no entry.
            m_complete_d = 1'b1;
            m_id_d       = id_q;
            m_len_d      = len_q;
          end else if (!free_q) begin
            m_drop_d = 1'b1;
          end else begin
            // Open a new entry in the lowest free slot.
            ram_we              = 1'b1;
            ram_waddr           = free_idx_q;
            ram_wdata           = '{frame_id: id_q, length: len_q, bytes_seen: frag_ext};
            valid_d[free_idx_q] = 1'b1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      chk_q     <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      chk_q     <= chk_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    len_q        <= len_d;
    frag_q       <= frag_d;
    hit_idx_q    <= hit_idx_d;
    hit_len_q    <= hit_len_d;
    hit_bytes_q  <= hit_bytes_d;
    free_idx_q   <= free_idx_d;
    m_complete_q <= m_complete_d;
    m_drop_q     <= m_drop_d;
    m_id_q       <= m_id_d;
    m_len_q      <= m_len_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(frt_pkg::MDataW - IdW - LenW){1'b0}}, m_len_q, m_id_q};
  assign m_axis_tuser  = {m_drop_q, m_complete_q};

`ifndef SYNTHESIS
  // One fragment at a time: a transfer closes the input until the result is loaded.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a fragment is in progress");

  // At most one entry opens per fragment.
  a_valid_growth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) <= $past($countones(valid_q)) + 1)
    else $error("more than one table entry opened at once");

  // A completed frame and a drop never come together.
  a_complete_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both complete and drop");

  // Frame number and length read as zero unless a frame completed.
  a_zero_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("result data not zero without completion");
`endif

endmodule

// ----- dv/frame_reassembly_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// frame_reassembly_tracker_tb
// Self-checking bench for the frame reassembly tracker. Fragments go in over
// the slave stream. A table tracker in the bench predicts each result, and
// every result transfer is checked against the oldest prediction. Directed
// cases come first: single-fragment frames, interleaved and duplicate frames,
// overshoot, byte count saturation and a full table. Then a long hold-off on
// the result side, and random traffic with and without idle bursts on both sides.
// ----------------------------------------------------------------------------
module frame_reassembly_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdW    = frt_pkg::IdW;
  localparam int unsigned LenW   = frt_pkg::LenW;
  localparam int unsigned FragW  = frt_pkg::FragW;
  localparam int unsigned SDataW = frt_pkg::SDataW;
  localparam int unsigned MDataW = frt_pkg::MDataW;
  localparam int unsigned MUserW = frt_pkg::MUserW;
  localparam logic [LenW-1:0] LenMax = frt_pkg::LenMax;

  localparam int unsigned Entries       = frt_pkg::TableEntriesDef;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 2 * (Entries + 2) + 4;
  localparam int unsigned MaxReported   = 10;
  localparam logic [FragW-1:0] FragMax  = '1;

  typedef struct packed {
    logic            complete;
    logic [IdW-1:0]  frame_id;
    logic [LenW-1:0] length;
    logic            drop;
  } frame_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SDataW-1:0]  s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [MDataW-1:0]  m_axis_tdata;
  logic [MUserW-1:0]  m_axis_tuser;

  // Bench copy of the open-frame table.
  logic            open_valid [Entries];
  logic [IdW-1:0]  open_id    [Entries];
  logic [LenW-1:0] open_len   [Entries];
  logic [LenW-1:0] open_seen  [Entries];

  frame_result_t expected_results[$];

  int unsigned fragments_sent   = 0;
  int unsigned results_seen     = 0;
  int unsigned frames_completed = 0;
  int unsigned frames_dropped   = 0;
  int unsigned mismatches       = 0;
  int unsigned quiet_cycles     = 0;
  bit          idle_en          = 1'b1;
  bit          hold_req         = 1'b0;

  always #1 clk_i = ~clk_i;

  frame_reassembly_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    for (int i = 0; i < Entries; i++) begin
      open_valid[i] = 1'b0;
      open_id[i]    = '0;
      open_len[i]   = '0;
      open_seen[i]  = '0;
    end
  end

  // Advance the table by one fragment and return the result it causes.
  function automatic frame_result_t account_fragment(logic [IdW-1:0] id,
                                                     logic [LenW-1:0] len,
                                                     logic [FragW-1:0] frag);
    frame_result_t res;
    int            hit;
    int            free_idx;
    logic [LenW:0] sum;
    res      = '0;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < Entries; i++) begin
      if (open_valid[i]) begin
        if (hit < 0 && open_id[i] == id) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      // Matching frame: ignore the header length, saturate the count.
      sum = {1'b0, open_seen[hit]} + (LenW + 1)'(frag);
      if (sum > {1'b0, LenMax}) sum = {1'b0, LenMax};
      open_seen[hit] = sum[LenW-1:0];
      if (open_seen[hit] == open_len[hit]) begin
        open_valid[hit] = 1'b0;
        res.complete    = 1'b1;
        res.frame_id    = open_id[hit];
        res.length      = open_len[hit];
      end
    end else if (LenW'(frag) == len) begin
      // Whole frame in one fragment: no entry taken, no drop even when full.
      res.complete = 1'b1;
      res.frame_id = id;
      res.length   = len;
    end else if (free_idx < 0) begin
      res.drop = 1'b1;
    end else begin
      open_valid[free_idx] = 1'b1;
      open_id[free_idx]    = id;
      open_len[free_idx]   = len;
      open_seen[free_idx]  = LenW'(frag);
    end
    return res;
  endfunction

  // Entries whose count already passed their length.
  function automatic int unsigned count_overshot();
    int unsigned n;
    n = 0;
    for (int i = 0; i < Entries; i++)
      if (open_valid[i] && open_seen[i] > open_len[i]) n++;
    return n;
  endfunction

  // Offer one fragment, hold it until transferred, then record the prediction.
  task automatic send_fragment(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                               input logic [FragW-1:0] frag);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {frag, len, id};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(account_fragment(id, len, frag));
    fragments_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input frame_result_t want,
                               input frame_result_t got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t mismatch (%s): expected complete=%0b id=%h len=%h drop=%0b",
               $time, what, want.complete, want.frame_id, want.length, want.drop);
      $display("    got complete=%0b id=%h len=%h drop=%0b",
               got.complete, got.frame_id, got.length, got.drop);
    end
  endtask

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.complete = m_axis_tuser[0];
      got.drop     = m_axis_tuser[1];
      got.frame_id = m_axis_tdata[IdW-1:0];
      got.length   = m_axis_tdata[IdW+LenW-1:IdW];
      results_seen++;
      if (got.complete) frames_completed++;
      if (got.drop) frames_dropped++;
      if (expected_results.size() == 0) begin
        note_mismatch("no result expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) note_mismatch("field", want, got);
      end
    end
  end

  // End the run when no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WatchdogLimit, expected_results.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: long hold-off on request, else random stall bursts.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_single_fragment();
    send_fragment('0, '0, '0);
    send_fragment('1, 24'(FragMax), FragMax);
    send_fragment(32'h8000_0001, 24'd1, 16'd1);
  endtask

  task automatic test_multi_fragment();
    // Header length of later fragments must be ignored.
    send_fragment(32'h0000_1234, 24'd300, 16'd100);
    send_fragment(32'h0000_1234, LenMax, 16'd0);
    send_fragment(32'h0000_1234, 24'd7, 16'd200);
    // Zero-byte opener, then a repeat of the same number updates that entry.
    send_fragment(32'h7FFF_FFFF, 24'd5, 16'd0);
    send_fragment(32'h7FFF_FFFF, 24'd9, 16'd2);
    send_fragment(32'h7FFF_FFFF, 24'd0, 16'd3);
    // Interleave two frames.
    send_fragment(32'h0000_00AA, 24'd10, 16'd4);
    send_fragment(32'h0000_00BB, 24'd20, 16'd10);
    send_fragment(32'h0000_00AA, 24'd10, 16'd6);
    send_fragment(32'h0000_00BB, 24'd20, 16'd10);
  endtask

  task automatic test_overshoot();
    // Count passes the length: entry stays open for the rest of the run.
    send_fragment(32'h0B0B_0B0B, 24'd50, 16'd40);
    send_fragment(32'h0B0B_0B0B, 24'd0, 16'd30);
    send_fragment(32'h0B0B_0B0B, 24'd50, 16'd0);
  endtask

  task automatic test_saturation();
    // Full-length frame: 256 max fragments, then one more saturates the count.
    for (int i = 0; i < 256; i++) send_fragment(32'h5A7_0000, LenMax, FragMax);
    send_fragment(32'h5A7_0000, '0, FragMax);
  endtask

  task automatic test_table_full();
    int unsigned n;
    n = 0;
    for (int i = 0; i < Entries; i++)
      if (!open_valid[i]) n++;
    for (int i = 0; i < n; i++) send_fragment(32'hA000_0000 + i, 24'd1000, 16'd1);
    send_fragment(32'h5EED_0001, LenMax, 16'd7);
    send_fragment(32'h5EED_0002, 24'd4660, 16'd4660);
    // Free one entry, refill it.
    send_fragment(32'hA000_0000, 24'd0, 16'd999);
    send_fragment(32'h5EED_0003, 24'd800, 16'd8);
  endtask

  task automatic test_backpressure();
    logic [FragW-1:0] frag;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      frag = FragW'($urandom());
      send_fragment($urandom(), 24'(frag), frag);
    end
  endtask

  task automatic test_sender_pause();
    pause_until_drained();
  endtask

  task automatic test_random(input int unsigned items, input bit allow_idle);
    int unsigned     r;
    int unsigned     pick;
    int unsigned     idx;
    int unsigned     overshot;
    int unsigned     fill_pct;
    int              open_idx[$];
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic [LenW-1:0] remaining;
    logic [FragW-1:0] frag;
    for (int k = 0; k < items; k++) begin
      // Pick a filling or draining phase at random every 120 items so the table fills and empties.
      if (k % 120 == 0) fill_pct = $urandom_range(0, 1) ? 25 : 70;
      idle_en = allow_idle && (k % 200 < 150);
      open_idx.delete();
      for (int i = 0; i < Entries; i++)
        if (open_valid[i]) open_idx.push_back(i);
      overshot = count_overshot();
      r    = $urandom_range(0, 99);
      id   = $urandom();
      len  = LenW'($urandom());
      frag = FragW'($urandom());
      if (open_idx.size() != 0 && r < fill_pct) begin
        // Continue an open frame; len keeps its random value.
        idx = open_idx[$urandom_range(0, open_idx.size() - 1)];
        id  = open_id[idx];
        if (open_seen[idx] > open_len[idx]) begin
          frag = FragW'($urandom_range(0, 255));
        end else begin
          remaining = open_len[idx] - open_seen[idx];
          pick      = $urandom_range(0, 9);
          if (pick < 6)
            frag = (remaining > FragMax) ? FragMax : remaining[FragW-1:0];
          else if (pick < 9 || overshot >= 2 || remaining >= FragMax)
            frag = FragW'($urandom_range(0, (remaining > FragMax) ? FragMax : remaining));
          else
            frag = FragW'($urandom_range(remaining + 1, FragMax));
        end
      end else if (r < 80) begin
        // New multi-fragment frame; on a full table the fragment is dropped unless it completes its frame.
        if (open_idx.size() != Entries) begin
          len  = LenW'($urandom_range(1, 3000));
          frag = FragW'($urandom_range(0, len - 1));
        end
      end else if (r < 92) begin
        len  = LenW'($urandom_range(0, FragMax));
        frag = len[FragW-1:0];
      end else begin
        // Noise: short random frame; keep overshooting entries rare.
        len = LenW'($urandom_range(0, FragMax));
        if (LenW'(frag) > len && overshot >= 2) frag = FragW'($urandom_range(0, len));
      end
      send_fragment(id, len, frag);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_fragment();
    test_multi_fragment();
    test_overshoot();
    test_saturation();
    test_table_full();
    test_backpressure();
    test_random(600, 1'b1);
    test_sender_pause();
    test_random(500, 1'b1);
    test_random(300, 1'b0);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d fragments, %0d results: %0d frames completed, %0d dropped",
             fragments_sent, results_seen, frames_completed, frames_dropped);
    $display("incl. count saturation, overshoot, full table and a %0d-cycle output hold-off",
             HoldOffCycles);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
